// ----- rtl/core/crbd_pkg.sv -----
// Shared types and constants for the adaptive Rice block decoder.
// No dependencies.
package crbd_pkg;

    localparam int unsigned RUN_LIMIT = 4;

    typedef struct packed {
        logic [31:0] d;
        logic [31:0] prev;
        logic [31:0] mask;
        logic        pre;
    } t_unmap_req;

endpackage

// ----- rtl/core/crbd_unmap.sv -----
// Prediction unmapping of one mapped residual against the previous output.
// Depends on crbd_pkg.
module crbd_unmap import crbd_pkg::*; (
    input  t_unmap_req  i_req,
    output logic [31:0] o_value
);
    logic [32:0] w_x, w_xm, w_d, w_t, w_th, w_v;

    always_comb begin
        w_x  = {1'b0, i_req.prev & i_req.mask};
        w_xm = {1'b0, i_req.mask};
        w_d  = {1'b0, i_req.d & i_req.mask};
        w_t  = w_xm - w_x;
        w_th = (w_x < w_t) ? w_x : w_t;
        if (!i_req.pre) begin
            w_v = w_d;
        end else if (w_d <= {w_th[31:0], 1'b0}) begin
            if (w_d[0]) begin
                w_v = w_x - ((w_d + 33'd1) >> 1);
            end else begin
                w_v = w_x + (w_d >> 1);
            end
        end else if (w_th == w_x) begin
            w_v = w_d;
        end else begin
            w_v = w_xm - w_d;
        end
        o_value = w_v[31:0] & i_req.mask;
    end
endmodule

// ----- rtl/core/ccsds_rice_block_decoder.sv -----
// Adaptive Rice block decoder: bit-serial stream in, decoded samples out.
// Depends on crbd_pkg and crbd_unmap.
//
// Takes one compressed bit per transaction on the slave stream (bit 0 of tdata)
// and normally accepts one bit per cycle. Input stalls while a result waits
// that the master side has not taken, before the first low bit of each split
// sample until its high-part memory read is ready, while the extra result is
// put out when a second-extension bit yields two samples, while a split block
// with k = 0 (J - ref results) is played out of the high-part memory, and
// after every block while the block-in-segment count settles (it is reduced
// by the segment length until it is below it, as after the segment length was
// lowered). A zero-block run comes out as one transaction with a repeat count.
// tlast marks the last result caused by one input bit.
module ccsds_rice_block_decoder import crbd_pkg::*; #(
    parameter int MAX_BLOCK   = 64,
    parameter int MAX_SEGMENT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] in_bit, [7:1] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [31:0] sample, [50:32] repeat_count
    output logic        o_m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(MAX_BLOCK);
    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int SW = $clog2(MAX_SEGMENT + 1);

    localparam logic [1:0] REG_BPS = 2'd0;
    localparam logic [1:0] REG_BSZ = 2'd1;
    localparam logic [1:0] REG_SEG = 2'd2;
    localparam logic [1:0] REG_PRE = 2'd3;

    typedef enum logic [3:0] {
        M_ID, M_SREF, M_SFS, M_SLOW, M_LEBIT, M_LEREF,
        M_ZERO, M_SE, M_SE2, M_UNC, M_EMIT
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [5:0]  r_bps;
    logic [6:0]  r_bsz;
    logic [12:0] r_segb;
    logic        r_pre;
    logic [4:0]  r_opt, n_opt;
    logic [31:0] r_shift, n_shift;
    logic [5:0]  r_fb, n_fb;
    logic [31:0] r_zrl, n_zrl;
    logic [31:0] r_beta, n_beta;
    logic [BW-1:0] r_bidx, n_bidx;
    logic [BW-1:0] r_sei, n_sei;
    logic [31:0] r_prev, n_prev;
    logic [SW-1:0] r_bis, n_bis;
    logic        r_bwrap, n_bwrap;
    logic        r_ref, n_ref;
    logic        r_ov, n_ov;
    logic [31:0] r_osamp, n_osamp;
    logic [18:0] r_orep, n_orep;
    logic        r_olast, n_olast;
    logic        r_hp_ok;
    logic [31:0] r_hp_rd;
    logic [31:0] r_mem [MAX_BLOCK];

    logic        mem_we;
    logic [AW-1:0] mem_wa;
    logic        w_wr, w_free, w_bit, w_acc, w_rdy_mode;
    logic [5:0]  w_n, w_fb_nx;
    logic [31:0] w_mask, w_shift_nx, w_split_sh, w_raw, um_v, um_d;
    logic [2:0]  w_idlen;
    logic [4:0]  w_idmask, w_id, w_k;
    logic [BW-1:0] w_j, w_bidx1, w_sei1;
    logic [SW-1:0] w_s, w_rem, w_z;
    logic [31:0] w_zc;
    logic [18:0] w_rep;
    logic        w_done_n, w_done_id, w_done_k;
    t_unmap_req  um_req;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_BPS: prdata = {26'd0, r_bps};
            REG_BSZ: prdata = {25'd0, r_bsz};
            REG_SEG: prdata = {19'd0, r_segb};
            REG_PRE: prdata = {31'd0, r_pre};
            default: prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (r_bps == 6'd0) begin
            w_n = 6'd1;
        end else if (r_bps > 6'd32) begin
            w_n = 6'd32;
        end else begin
            w_n = r_bps;
        end
        w_mask  = 32'hFFFF_FFFF >> (6'd32 - w_n);
        w_idlen = (w_n > 6'd16) ? 3'd5 : ((w_n > 6'd8) ? 3'd4 : 3'd3);
        w_idmask = 5'((6'd1 << w_idlen) - 6'd1);
        if (r_bsz < 7'd8) begin
            w_j = BW'(8);
        end else if (r_bsz > 7'(MAX_BLOCK)) begin
            w_j = BW'(MAX_BLOCK) & ~BW'(1);
        end else begin
            w_j = BW'(r_bsz) & ~BW'(1);
        end
        if (r_segb == 13'd0) begin
            w_s = SW'(1);
        end else if (r_segb > 13'(MAX_SEGMENT)) begin
            w_s = SW'(MAX_SEGMENT);
        end else begin
            w_s = SW'(r_segb);
        end
        w_k = r_opt - 5'd1;
    end

    assign w_bit      = i_s_axis_tdata[0];
    assign w_free     = !r_ov || i_m_axis_tready;
    assign w_shift_nx = {r_shift[30:0], w_bit};
    assign w_split_sh = (r_fb == 6'd0) ? {r_hp_rd[30:0], w_bit} : w_shift_nx;
    assign w_fb_nx    = r_fb + 6'd1;
    assign w_done_n   = w_fb_nx >= w_n;
    assign w_done_id  = w_fb_nx >= {3'd0, w_idlen};
    assign w_done_k   = w_fb_nx >= {1'b0, w_k};
    assign w_raw      = w_shift_nx & w_mask;
    assign w_id       = w_shift_nx[4:0] & w_idmask;
    assign w_bidx1    = r_bidx + BW'(1);
    assign w_sei1     = r_sei + BW'(1);

    always_comb begin
        w_rem = (r_bis < w_s) ? (w_s - r_bis) : SW'(1);
        if (r_zrl < 32'(RUN_LIMIT)) begin
            w_zc = r_zrl + 32'd1;
        end else if (r_zrl == 32'(RUN_LIMIT)) begin
            w_zc = 32'(w_rem);
        end else begin
            w_zc = r_zrl;
        end
        w_z   = (w_zc > 32'(w_rem)) ? w_rem : SW'(w_zc);
        w_rep = 19'(19'(w_z) * 19'(w_j)) - 19'(r_ref);
    end

    always_comb begin
        unique case (r_mode)
            M_SLOW:  um_d = w_split_sh;
            M_SE:    um_d = r_sei[0] ? r_zrl : (r_beta - r_zrl);
            M_SE2:   um_d = r_zrl;
            M_UNC:   um_d = w_shift_nx;
            M_EMIT:  um_d = r_hp_rd;
            default: um_d = 32'd0;
        endcase
    end

    assign um_req = '{d: um_d, prev: r_prev, mask: w_mask, pre: r_pre};

    crbd_unmap u_unmap (
        .i_req  (um_req),
        .o_value(um_v)
    );

    always_comb begin
        unique case (r_mode)
            M_SE2, M_EMIT: w_rdy_mode = 1'b0;
            M_SLOW:        w_rdy_mode = (r_fb != 6'd0) || r_hp_ok;
            default:       w_rdy_mode = 1'b1;
        endcase
    end

    assign o_s_axis_tready = w_free && w_rdy_mode && !r_bwrap;
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_mode  = r_mode;
        n_opt   = r_opt;
        n_shift = r_shift;
        n_fb    = r_fb;
        n_zrl   = r_zrl;
        n_beta  = r_beta;
        n_bidx  = r_bidx;
        n_sei   = r_sei;
        n_prev  = r_prev;
        n_bis   = r_bis;
        n_bwrap = r_bwrap;
        n_ref   = r_ref;
        n_ov    = r_ov && !i_m_axis_tready;
        n_osamp = r_osamp;
        n_orep  = r_orep;
        n_olast = r_olast;
        mem_we  = 1'b0;
        mem_wa  = r_bidx[AW-1:0];

        // block count modulo segment length, one subtraction per cycle
        if (r_bwrap) begin
            if (r_bis >= w_s) begin
                n_bis = r_bis - w_s;
            end else begin
                n_bwrap = 1'b0;
            end
        end

        if (w_acc) begin
            unique case (r_mode)
                M_ID: begin
                    n_shift = w_shift_nx;
                    n_fb    = w_fb_nx;
                    if (w_done_id) begin
                        n_ref   = r_pre && (r_bis == '0);
                        n_opt   = w_id;
                        n_zrl   = 32'd0;
                        n_shift = 32'd0;
                        n_fb    = 6'd0;
                        n_bidx  = '0;
                        if (w_id == 5'd0) begin
                            n_mode = M_LEBIT;
                        end else if (w_id == w_idmask) begin
                            n_mode = M_UNC;
                        end else begin
                            n_mode = (r_pre && (r_bis == '0)) ? M_SREF : M_SFS;
                        end
                    end
                end
                M_SREF: begin
                    n_shift = w_shift_nx;
                    n_fb    = w_fb_nx;
                    if (w_done_n) begin
                        n_ov = 1'b1; n_osamp = w_raw; n_orep = 19'd1; n_olast = 1'b1;
                        n_prev  = w_raw;
                        n_bidx  = BW'(1);
                        n_zrl   = 32'd0;
                        n_shift = 32'd0;
                        n_fb    = 6'd0;
                        n_mode  = M_SFS;
                    end
                end
                M_SFS: begin
                    if (!w_bit) begin
                        if (r_zrl != 32'hFFFF_FFFF) n_zrl = r_zrl + 32'd1;
                    end else begin
                        mem_we = (r_bidx < BW'(MAX_BLOCK));
                        n_zrl  = 32'd0;
                        if (w_bidx1 >= w_j) begin
                            n_bidx = BW'(r_ref);
                            n_mode = (w_k == 5'd0) ? M_EMIT : M_SLOW;
                        end else begin
                            n_bidx = w_bidx1;
                        end
                    end
                end
                M_SLOW: begin
                    n_shift = w_split_sh;
                    n_fb    = w_fb_nx;
                    if (w_done_k) begin
                        n_ov = 1'b1; n_osamp = um_v; n_orep = 19'd1; n_olast = 1'b1;
                        n_prev  = um_v;
                        n_shift = 32'd0;
                        n_fb    = 6'd0;
                        if (w_bidx1 >= w_j) begin
                            n_bis   = r_bis + SW'(1);
                            n_bwrap = 1'b1;
                            n_mode  = M_ID;
                        end else begin
                            n_bidx = w_bidx1;
                        end
                    end
                end
                M_LEBIT: begin
                    n_opt = {4'd0, w_bit};
                    if (r_ref) begin
                        n_mode = M_LEREF;
                    end else begin
                        n_zrl  = 32'd0;
                        n_beta = 32'd0;
                        n_sei  = BW'(r_ref);
                        n_mode = w_bit ? M_SE : M_ZERO;
                    end
                end
                M_LEREF: begin
                    n_shift = w_shift_nx;
                    n_fb    = w_fb_nx;
                    if (w_done_n) begin
                        n_ov = 1'b1; n_osamp = w_raw; n_orep = 19'd1; n_olast = 1'b1;
                        n_prev  = w_raw;
                        n_shift = 32'd0;
                        n_fb    = 6'd0;
                        n_zrl   = 32'd0;
                        n_beta  = 32'd0;
                        n_sei   = BW'(r_ref);
                        n_mode  = (r_opt == 5'd1) ? M_SE : M_ZERO;
                    end
                end
                M_ZERO: begin
                    if (!w_bit) begin
                        if (r_zrl != 32'hFFFF_FFFF) n_zrl = r_zrl + 32'd1;
                    end else begin
                        n_ov = 1'b1; n_orep = w_rep; n_olast = 1'b1;
                        n_osamp = r_pre ? (r_prev & w_mask) : 32'd0;
                        n_prev  = r_pre ? (r_prev & w_mask) : 32'd0;
                        n_zrl   = 32'd0;
                        n_bis   = r_bis + w_z;
                        n_bwrap = 1'b1;
                        n_shift = 32'd0;
                        n_fb    = 6'd0;
                        n_mode  = M_ID;
                    end
                end
                M_SE: begin
                    if (!w_bit) begin
                        if (r_zrl >= r_beta) begin
                            if (r_beta != 32'hFFFF_FFFF) begin
                                n_beta = r_beta + 32'd1;
                                n_zrl  = 32'd0;
                            end
                        end else begin
                            n_zrl = r_zrl + 32'd1;
                        end
                    end else begin
                        n_ov = 1'b1; n_osamp = um_v; n_orep = 19'd1;
                        n_prev = um_v;
                        n_sei  = w_sei1;
                        if (!r_sei[0] && (w_sei1 < w_j)) begin
                            n_olast = 1'b0;
                            n_mode  = M_SE2;
                        end else begin
                            n_olast = 1'b1;
                            n_zrl   = 32'd0;
                            n_beta  = 32'd0;
                            if (w_sei1 >= w_j) begin
                                n_bis   = r_bis + SW'(1);
                                n_bwrap = 1'b1;
                                n_shift = 32'd0;
                                n_fb    = 6'd0;
                                n_mode  = M_ID;
                            end
                        end
                    end
                end
                M_UNC: begin
                    n_shift = w_shift_nx;
                    n_fb    = w_fb_nx;
                    if (w_done_n) begin
                        n_ov = 1'b1; n_orep = 19'd1; n_olast = 1'b1;
                        if (r_bidx == '0 && r_ref) begin
                            n_osamp = w_raw;
                            n_prev  = w_raw;
                        end else begin
                            n_osamp = um_v;
                            n_prev  = um_v;
                        end
                        n_shift = 32'd0;
                        n_fb    = 6'd0;
                        n_bidx  = w_bidx1;
                        if (w_bidx1 >= w_j) begin
                            n_bis   = r_bis + SW'(1);
                            n_bwrap = 1'b1;
                            n_mode  = M_ID;
                        end
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end else if (r_mode == M_SE2 && w_free) begin
            n_ov = 1'b1; n_osamp = um_v; n_orep = 19'd1; n_olast = 1'b1;
            n_prev = um_v;
            n_sei  = w_sei1;
            n_zrl  = 32'd0;
            n_beta = 32'd0;
            if (w_sei1 >= w_j) begin
                n_bis   = r_bis + SW'(1);
                n_bwrap = 1'b1;
                n_shift = 32'd0;
                n_fb    = 6'd0;
                n_mode  = M_ID;
            end else begin
                n_mode = M_SE;
            end
        end else if (r_mode == M_EMIT && w_free && r_hp_ok) begin
            n_ov = 1'b1; n_osamp = um_v; n_orep = 19'd1;
            n_prev  = um_v;
            n_olast = (w_bidx1 >= w_j);
            if (w_bidx1 >= w_j) begin
                n_bis   = r_bis + SW'(1);
                n_bwrap = 1'b1;
                n_shift = 32'd0;
                n_fb    = 6'd0;
                n_mode  = M_ID;
            end else begin
                n_bidx = w_bidx1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= r_zrl;
        end
        r_hp_rd <= r_mem[r_bidx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_ID;
            r_bps   <= 6'd8;
            r_bsz   <= 7'd16;
            r_segb  <= 13'd128;
            r_pre   <= 1'b1;
            r_opt   <= 5'd0;
            r_shift <= 32'd0;
            r_fb    <= 6'd0;
            r_zrl   <= 32'd0;
            r_beta  <= 32'd0;
            r_bidx  <= '0;
            r_sei   <= '0;
            r_prev  <= 32'd0;
            r_bis   <= '0;
            r_bwrap <= 1'b0;
            r_ref   <= 1'b0;
            r_ov    <= 1'b0;
            r_hp_ok <= 1'b0;
        end else begin
            if (w_wr) begin
                unique case (paddr[3:2])
                    REG_BPS: r_bps  <= pwdata[5:0];
                    REG_BSZ: r_bsz  <= pwdata[6:0];
                    REG_SEG: r_segb <= pwdata[12:0];
                    REG_PRE: r_pre  <= pwdata[0];
                    default: r_pre  <= r_pre;
                endcase
            end
            r_mode  <= n_mode;
            r_opt   <= n_opt;
            r_shift <= n_shift;
            r_fb    <= n_fb;
            r_zrl   <= n_zrl;
            r_beta  <= n_beta;
            r_bidx  <= n_bidx;
            r_sei   <= n_sei;
            r_prev  <= n_prev;
            r_bis   <= n_bis;
            r_bwrap <= n_bwrap;
            r_ref   <= n_ref;
            r_ov    <= n_ov;
            r_hp_ok <= (n_bidx == r_bidx) && !mem_we;
        end
        r_osamp <= n_osamp;
        r_orep  <= n_orep;
        r_olast <= n_olast;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {5'd0, r_orep, r_osamp};
    assign o_m_axis_tlast  = r_olast;

    a_emit_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_EMIT || r_mode == M_SE2) |-> !o_s_axis_tready)
        else $error("input taken while results are played out");
    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!r_ov || i_m_axis_tready))
        else $error("input taken with output slot full");
    a_bis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bis <= SW'(MAX_SEGMENT))
        else $error("block-in-segment counter out of range");
    a_split_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_SLOW || r_mode == M_EMIT) |-> (r_bidx < BW'(MAX_BLOCK)))
        else $error("high-part index out of range");
    a_se2_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_mode == M_SE && n_mode == M_SE2) |=> (r_ov && !r_olast))
        else $error("first of a second-extension pair not marked non-last");
endmodule
